/* design/seq_pkg.sv */
// Package for the sorted event queue: operation and status codes,
// default sizes and the control word that steers the row of cells.
// No dependencies.
package seq_pkg;

    localparam int DEPTH_DEF       = 16;
    localparam int KEY_BITS_DEF    = 32;
    localparam int HANDLE_BITS_DEF = 16;
    localparam int FILL_BITS       = 5;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_POP    = 2'd1;
    localparam logic [1:0] KIND_PUSH   = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic ins;
        logic push;
        logic pop;
    } t_cell_op;

endpackage

/* design/seq_if.sv */
// Valid/ready channel interfaces for the sorted event queue: the
// operation word going in and the result word coming out.
// Depends on seq_pkg for default widths.
interface seq_in_if #(
    parameter int KEY_BITS    = seq_pkg::KEY_BITS_DEF,
    parameter int HANDLE_BITS = seq_pkg::HANDLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [1:0]             kind;
    logic [KEY_BITS-1:0]    event_key;
    logic [HANDLE_BITS-1:0] event_handle;

    modport source (output valid, kind, event_key, event_handle, input ready);
    modport sink   (input valid, kind, event_key, event_handle, output ready);
endinterface

interface seq_out_if #(
    parameter int KEY_BITS    = seq_pkg::KEY_BITS_DEF,
    parameter int HANDLE_BITS = seq_pkg::HANDLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [1:0]             status;
    logic [KEY_BITS-1:0]    popped_key;
    logic [HANDLE_BITS-1:0] popped_handle;
    logic [seq_pkg::FILL_BITS-1:0] fill_count;

    modport source (output valid, status, popped_key, popped_handle, fill_count,
                    input ready);
    modport sink   (input valid, status, popped_key, popped_handle, fill_count,
                    output ready);
endinterface

/* design/seq_cell.sv */
// One slot of the queue: holds a key, a handle and a valid bit, and
// moves toward the tail, the head or takes the new word per the op.
// Depends on seq_pkg.
module seq_cell #(
    parameter int KEY_BITS    = seq_pkg::KEY_BITS_DEF,
    parameter int HANDLE_BITS = seq_pkg::HANDLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  seq_pkg::t_cell_op      i_op,
    input  logic [KEY_BITS-1:0]    i_new_key,
    input  logic [HANDLE_BITS-1:0] i_new_handle,
    input  logic [KEY_BITS-1:0]    i_left_key,
    input  logic [HANDLE_BITS-1:0] i_left_handle,
    input  logic                   i_left_valid,
    input  logic [KEY_BITS-1:0]    i_right_key,
    input  logic [HANDLE_BITS-1:0] i_right_handle,
    input  logic                   i_right_valid,
    input  logic                   i_found,
    output logic                   o_found,
    output logic [KEY_BITS-1:0]    o_key,
    output logic [HANDLE_BITS-1:0] o_handle,
    output logic                   o_valid
);
    import seq_pkg::*;

    logic [KEY_BITS-1:0]    r_key, n_key;
    logic [HANDLE_BITS-1:0] r_handle, n_handle;
    logic                   r_valid, n_valid;
    logic                   stay;

    // entry stays ahead of an ordered insert
    assign stay    = r_valid && (r_key <= i_new_key);
    assign o_found = i_found || !stay;

    always_comb begin
        n_key    = r_key;
        n_handle = r_handle;
        n_valid  = r_valid;
        if (i_op.pop) begin
            n_key    = i_right_key;
            n_handle = i_right_handle;
            n_valid  = i_right_valid;
        end else if (i_op.push || (i_op.ins && i_found)) begin
            n_key    = i_left_key;
            n_handle = i_left_handle;
            n_valid  = i_left_valid;
        end else if (i_op.ins && !stay) begin
            n_key    = i_new_key;
            n_handle = i_new_handle;
            n_valid  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_handle <= n_handle;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_key    = r_key;
    assign o_handle = r_handle;
    assign o_valid  = r_valid;

endmodule

/* design/sorted_event_queue.sv */
// Sorted event queue: a row of DEPTH cells kept in head-first order.
// Each result word is registered and is presented in the cycle after its operation word is accepted.
// Throughput: one word per cycle while the result side is ready; every cell
// compares its key with the new key and shifts in the same cycle, and a
// result word that waits in the output register holds off the input.
// Reset empties the queue.
module sorted_event_queue #(
    parameter int DEPTH       = seq_pkg::DEPTH_DEF,
    parameter int KEY_BITS    = seq_pkg::KEY_BITS_DEF,
    parameter int HANDLE_BITS = seq_pkg::HANDLE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    seq_in_if.sink    i_in,
    seq_out_if.source o_out
);
    import seq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [KEY_BITS-1:0]    cell_key    [DEPTH];
    logic [HANDLE_BITS-1:0] cell_handle [DEPTH];
    logic [DEPTH-1:0]       cell_valid;
    logic [DEPTH:0]         found;
    t_cell_op               op;

    logic                   accept, full, empty;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [CNT_W+FILL_BITS-1:0] count_ext;
    logic                   r_out_valid;
    logic [1:0]             r_status, n_status;
    logic [KEY_BITS-1:0]    r_pkey, n_pkey;
    logic [HANDLE_BITS-1:0] r_phandle, n_phandle;
    logic [FILL_BITS-1:0]   r_fill;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign full       = cell_valid[DEPTH-1];
    assign empty      = !cell_valid[0];

    always_comb begin
        op        = '0;
        n_status  = STATUS_OK;
        n_pkey    = '0;
        n_phandle = '0;
        n_count   = r_count;
        case (i_in.kind)
            KIND_INSERT, KIND_PUSH: begin
                if (full) begin
                    n_status = STATUS_FULL;
                end else begin
                    op.ins  = accept && (i_in.kind == KIND_INSERT);
                    op.push = accept && (i_in.kind == KIND_PUSH);
                    n_count = r_count + CNT_W'(1);
                end
            end
            KIND_POP: begin
                if (empty) begin
                    n_status = STATUS_EMPTY;
                end else begin
                    op.pop    = accept;
                    n_pkey    = cell_key[0];
                    n_phandle = cell_handle[0];
                    n_count   = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_status = STATUS_OK;
            end
        endcase
    end

    assign count_ext = {{FILL_BITS{1'b0}}, n_count};
    assign found[0]  = 1'b0;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [KEY_BITS-1:0]    left_key, right_key;
            logic [HANDLE_BITS-1:0] left_handle, right_handle;
            logic                   left_valid, right_valid;

            if (g == 0) begin : g_head
                assign left_key    = i_in.event_key;
                assign left_handle = i_in.event_handle;
                assign left_valid  = 1'b1;
            end else begin : g_mid
                assign left_key    = cell_key[g-1];
                assign left_handle = cell_handle[g-1];
                assign left_valid  = cell_valid[g-1];
            end

            if (g == DEPTH - 1) begin : g_tail
                assign right_key    = '0;
                assign right_handle = '0;
                assign right_valid  = 1'b0;
            end else begin : g_body
                assign right_key    = cell_key[g+1];
                assign right_handle = cell_handle[g+1];
                assign right_valid  = cell_valid[g+1];
            end

            seq_cell #(
                .KEY_BITS    (KEY_BITS),
                .HANDLE_BITS (HANDLE_BITS)
            ) u_cell (
                .i_clk          (i_clk),
                .i_rst_n        (i_rst_n),
                .i_op           (op),
                .i_new_key      (i_in.event_key),
                .i_new_handle   (i_in.event_handle),
                .i_left_key     (left_key),
                .i_left_handle  (left_handle),
                .i_left_valid   (left_valid),
                .i_right_key    (right_key),
                .i_right_handle (right_handle),
                .i_right_valid  (right_valid),
                .i_found        (found[g]),
                .o_found        (found[g+1]),
                .o_key          (cell_key[g]),
                .o_handle       (cell_handle[g]),
                .o_valid        (cell_valid[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status  <= n_status;
            r_pkey    <= n_pkey;
            r_phandle <= n_phandle;
            r_fill    <= count_ext[FILL_BITS-1:0];
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (accept) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_status;
    assign o_out.popped_key    = r_pkey;
    assign o_out.popped_handle = r_phandle;
    assign o_out.fill_count    = r_fill;

endmodule

/* dv/seq_checker.sv */
// Checker for the sorted event queue: watches the operation and result channels,
// keeps its own ordered list of held events and compares each result word in order.
// Depends on seq_pkg and the channel interfaces in seq_if.sv.
module seq_checker #(
    parameter int DEPTH       = seq_pkg::DEPTH_DEF,
    parameter int KEY_BITS    = seq_pkg::KEY_BITS_DEF,
    parameter int HANDLE_BITS = seq_pkg::HANDLE_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    seq_in_if    i_op,
    seq_out_if   i_res,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import seq_pkg::*;

    typedef struct packed {
        logic [1:0]             status;
        logic [KEY_BITS-1:0]    key;
        logic [HANDLE_BITS-1:0] handle;
        logic [FILL_BITS-1:0]   fill;
    } t_result;

    logic [KEY_BITS-1:0]    held_keys    [DEPTH];
    logic [HANDLE_BITS-1:0] held_handles [DEPTH];
    int                     held_count = 0;
    t_result                predicted_results [$];
    int                     mismatches = 0;

    assign o_fail_count = mismatches;

    task automatic apply_queue_op(
        input  logic [1:0]             kind,
        input  logic [KEY_BITS-1:0]    key,
        input  logic [HANDLE_BITS-1:0] handle,
        output t_result                res
    );
        int pos;
        res        = '0;
        res.status = STATUS_OK;
        if (kind == KIND_INSERT || kind == KIND_PUSH) begin
            if (held_count >= DEPTH) begin
                res.status = STATUS_FULL;
            end else begin
                pos = 0;
                if (kind == KIND_INSERT) begin
                    while (pos < held_count && held_keys[pos] <= key)
                        pos++;
                end
                for (int i = held_count; i > pos; i--) begin
                    held_keys[i]    = held_keys[i-1];
                    held_handles[i] = held_handles[i-1];
                end
                held_keys[pos]    = key;
                held_handles[pos] = handle;
                held_count++;
            end
        end else if (kind == KIND_POP) begin
            if (held_count == 0) begin
                res.status = STATUS_EMPTY;
            end else begin
                res.key    = held_keys[0];
                res.handle = held_handles[0];
                for (int i = 1; i < held_count; i++) begin
                    held_keys[i-1]    = held_keys[i];
                    held_handles[i-1] = held_handles[i];
                end
                held_count--;
            end
        end
        res.fill = held_count[FILL_BITS-1:0];
    endtask

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            held_count = 0;
            predicted_results.delete();
        end else begin
            if (i_op.valid && i_op.ready) begin
                apply_queue_op(i_op.kind, i_op.event_key, i_op.event_handle, want);
                predicted_results.push_back(want);
            end
            if (i_res.valid && i_res.ready) begin
                got.status = i_res.status;
                got.key    = i_res.popped_key;
                got.handle = i_res.popped_handle;
                got.fill   = i_res.fill_count;
                if (predicted_results.size() == 0) begin
                    $error("result word with nothing expected: status %0d", got.status);
                    mismatches++;
                end else begin
                    want = predicted_results.pop_front();
                    check_field("status", 64'(want.status), 64'(got.status));
                    check_field("popped_key", 64'(want.key), 64'(got.key));
                    check_field("popped_handle", 64'(want.handle), 64'(got.handle));
                    check_field("fill_count", 64'(want.fill), 64'(got.fill));
                end
            end
        end
        o_pending <= predicted_results.size();
    end

endmodule

/* dv/testbench.sv */
// Top of the sorted event queue testbench: clock, reset, operation stimulus,
// result back-pressure, watchdog and verdict.
// Depends on seq_pkg, seq_if.sv, sorted_event_queue and seq_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import seq_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int KEY_BITS       = KEY_BITS_DEF;
    localparam int HANDLE_BITS    = HANDLE_BITS_DEF;
    localparam int PHASE_WORDS    = 60;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 10;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    bit   hold_req      = 1'b0;
    int   quiet_cycles  = 0;
    int   fail_count;
    int   pending_words;

    seq_in_if  in_ch ();
    seq_out_if out_ch ();

    sorted_event_queue dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    seq_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_op         (in_ch),
        .i_res        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_words)
    );

    always #4ns clk = ~clk;

    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                out_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_word(
        input logic [1:0]             kind,
        input logic [KEY_BITS-1:0]    key,
        input logic [HANDLE_BITS-1:0] handle
    );
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.kind         <= kind;
        in_ch.event_key    <= key;
        in_ch.event_handle <= handle;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    function automatic logic [KEY_BITS-1:0] pick_key();
        int r;
        r = $urandom_range(9);
        if (r < 5)
            return KEY_BITS'($urandom_range(15));
        else if (r == 5)
            return '0;
        else if (r == 6)
            return '1;
        return KEY_BITS'($urandom);
    endfunction

    task automatic run_phase(input int idle_pct, input int stall, input int insert_pct);
        int         done;
        int         r;
        logic [1:0] kind;
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        done          = 0;
        while (done < PHASE_WORDS) begin
            r = $urandom_range(99);
            if (r < 2)
                kind = KIND_UNUSED;
            else if (r < 2 + insert_pct)
                kind = ($urandom_range(4) == 0) ? KIND_PUSH : KIND_INSERT;
            else
                kind = KIND_POP;
            send_word(kind, pick_key(), HANDLE_BITS'($urandom));
            if (kind != KIND_UNUSED)
                done++;
        end
    endtask

    initial begin
        in_ch.valid        = 1'b0;
        in_ch.kind         = KIND_INSERT;
        in_ch.event_key    = '0;
        in_ch.event_handle = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(KIND_POP, '0, '0);
        send_word(KIND_UNUSED, '1, '1);
        send_word(KIND_INSERT, '1, '1);
        send_word(KIND_INSERT, '0, '0);
        send_word(KIND_INSERT, KEY_BITS'(100), HANDLE_BITS'(1));
        send_word(KIND_INSERT, KEY_BITS'(100), HANDLE_BITS'(2));
        send_word(KIND_INSERT, KEY_BITS'(100), HANDLE_BITS'(3));
        send_word(KIND_PUSH, KEY_BITS'(500), HANDLE_BITS'(4));
        send_word(KIND_INSERT, '1, HANDLE_BITS'(5));
        repeat (7) send_word(KIND_POP, '0, '0);
        send_word(KIND_POP, '1, '1);

        run_phase(0, 0, 50);
        run_phase(78, 0, 85);
        run_phase(0, 78, 15);
        run_phase(26, 26, 55);
        hold_req = 1'b1;
        run_phase(0, 0, 70);
        run_phase(78, 0, 20);
        run_phase(0, 78, 85);
        run_phase(26, 26, 45);

        in_ch.valid <= 1'b0;
        while (pending_words != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_words == 0) begin
            $display("SUCCESS");
        end else begin
            if (pending_words != 0)
                $error("%0d result words never arrived", pending_words);
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* sim.f */
design/seq_pkg.sv
design/seq_if.sv
design/seq_cell.sv
design/sorted_event_queue.sv
dv/seq_checker.sv
dv/testbench.sv
